// ===== rtl/core/file_name_validator_defines.svh =====
// ----------------------------------------------------------------------------
// File name validator assertion macros
// Shorthand for the clocked, reset-qualified checks in the validator core.
// ----------------------------------------------------------------------------
`ifndef FILE_NAME_VALIDATOR_DEFINES_SVH
`define FILE_NAME_VALIDATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FNV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FNV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/fnv_pkg.sv =====
// ----------------------------------------------------------------------------
// File name validator package
// Verdict codes, character codes and the stem type of the validator core.
// ----------------------------------------------------------------------------
package fnv_pkg;

  typedef logic [2:0] verdict_t;
  typedef logic [6:0] ascii_t;
  typedef ascii_t     stem_t [4];

  localparam verdict_t VERDICT_OK        = 3'd0;
  localparam verdict_t VERDICT_EMPTY     = 3'd1;
  localparam verdict_t VERDICT_RESERVED  = 3'd2;
  localparam verdict_t VERDICT_SEPARATOR = 3'd3;
  localparam verdict_t VERDICT_ILLEGAL   = 3'd4;
  localparam verdict_t VERDICT_TRAILING  = 3'd5;

  localparam ascii_t CH_CTRL_END  = 7'h20;
  localparam ascii_t CH_SPACE     = 7'h20;
  localparam ascii_t CH_DOT       = 7'h2E;
  localparam ascii_t CH_BACKSLASH = 7'h5C;
  localparam ascii_t CH_SLASH     = 7'h2F;
  localparam ascii_t CH_LT        = 7'h3C;
  localparam ascii_t CH_GT        = 7'h3E;
  localparam ascii_t CH_COLON     = 7'h3A;
  localparam ascii_t CH_QUOTE     = 7'h22;
  localparam ascii_t CH_PIPE      = 7'h7C;
  localparam ascii_t CH_QUESTION  = 7'h3F;
  localparam ascii_t CH_STAR      = 7'h2A;
  localparam ascii_t CH_DIGIT_1   = 7'h31;
  localparam ascii_t CH_DIGIT_9   = 7'h39;
  localparam ascii_t CH_LOWER_A   = 7'h61;
  localparam ascii_t CH_LOWER_Z   = 7'h7A;
  localparam ascii_t CASE_OFFSET  = 7'h20;

  localparam ascii_t CH_A = 7'h41;
  localparam ascii_t CH_C = 7'h43;
  localparam ascii_t CH_L = 7'h4C;
  localparam ascii_t CH_M = 7'h4D;
  localparam ascii_t CH_N = 7'h4E;
  localparam ascii_t CH_O = 7'h4F;
  localparam ascii_t CH_P = 7'h50;
  localparam ascii_t CH_R = 7'h52;
  localparam ascii_t CH_T = 7'h54;
  localparam ascii_t CH_U = 7'h55;
  localparam ascii_t CH_X = 7'h58;

  localparam logic [1:0] UNITS_MAX = 2'd3;
  localparam logic [2:0] STEM_KEEP = 3'd4;
  localparam logic [2:0] STEM_MAX  = 3'd5;
  localparam logic [2:0] STEM_LEN3 = 3'd3;
  localparam logic [2:0] STEM_LEN4 = 3'd4;

  // Fold ASCII lower case onto upper case.
  function automatic ascii_t fold_upper(input ascii_t c);
    ascii_t r;
    r = c;
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      r = c - CASE_OFFSET;
    end
    return r;
  endfunction

  function automatic logic word3_is(input ascii_t c0, input ascii_t c1, input ascii_t c2,
                                    input ascii_t w0, input ascii_t w1, input ascii_t w2);
    return (fold_upper(c0) == w0) && (fold_upper(c1) == w1) && (fold_upper(c2) == w2);
  endfunction

endpackage

// ===== rtl/core/file_name_validator.sv =====
// ----------------------------------------------------------------------------
// File name validator
// The last item of a name waits in the input register; its verdict is then loaded into the result register.
// Throughput: one item per cycle unless a held verdict stalls a last item; the single-pass update logic sets the rate.
// A held verdict stalls only the next last item; other items keep flowing.
// Reset clears all name state and both valid flags; the stem buffer is not reset.
// ----------------------------------------------------------------------------
`include "file_name_validator_defines.svh"

module file_name_validator #(
  parameter int CODE_UNIT_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // input channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [CODE_UNIT_BITS-1:0] code_unit_i,
  input  logic                      has_char_i,
  input  logic                      last_i,
  // result channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output fnv_pkg::verdict_t         verdict_o
);
  import fnv_pkg::*;

  // --------------------------------------------------------------------------
  // Input register: one item waits here while the update logic works on it.
  // --------------------------------------------------------------------------
  logic                      s1_valid_q;
  logic [CODE_UNIT_BITS-1:0] s1_unit_q;
  logic                      s1_has_char_q;
  logic                      s1_last_q;

  // Result register.
  logic     out_valid_q;
  verdict_t verdict_q;

  // Name state.
  verdict_t   fault_q, fault_d;
  logic [1:0] units_q, units_d;
  logic       only_dots_q, only_dots_d;
  logic [2:0] stem_len_q, stem_len_d;
  logic       stem_closed_q, stem_closed_d;
  logic       non_ascii_q, non_ascii_d;
  logic       ends_ds_q, ends_ds_d;
  stem_t      stem_q, stem_d;

  logic     in_accept;
  logic     out_free;
  logic     advance;
  logic     out_load;
  logic     is_ascii;
  ascii_t   low7;
  logic     is_dot;
  logic     is_space;
  logic     is_sep;
  logic     is_illegal;
  logic     stem_reserved;
  verdict_t verdict_d;

  // The output register is free when empty or when its verdict leaves now.
  assign out_free  = !out_valid_q || !out_stall_i;
  // A non-last item never needs the output, so only a last item waits on it.
  assign advance   = s1_valid_q && (!s1_last_q || out_free);
  assign out_load  = advance && s1_last_q;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_unit_q     <= code_unit_i;
      s1_has_char_q <= has_char_i;
      s1_last_q     <= last_i;
    end
  end

  // --------------------------------------------------------------------------
  // Classify the code unit. Anything at 0x80 or above is non-ASCII and
  // matches none of the special characters.
  // --------------------------------------------------------------------------
  always_comb begin
    is_ascii   = ~|s1_unit_q[CODE_UNIT_BITS-1:7];
    low7       = s1_unit_q[6:0];
    is_dot     = is_ascii && (low7 == CH_DOT);
    is_space   = is_ascii && (low7 == CH_SPACE);
    is_sep     = is_ascii && (low7 inside {CH_BACKSLASH, CH_SLASH});
    is_illegal = is_ascii && ((low7 < CH_CTRL_END) ||
                 (low7 inside {CH_LT, CH_GT, CH_COLON, CH_QUOTE, CH_PIPE, CH_QUESTION,
                               CH_STAR}));
  end

  // --------------------------------------------------------------------------
  // Fold the unit into the name state. The verdict is taken from the updated
  // state, so the last unit of a name counts toward its own verdict.
  // --------------------------------------------------------------------------
  always_comb begin
    fault_d       = fault_q;
    units_d       = units_q;
    only_dots_d   = only_dots_q;
    stem_len_d    = stem_len_q;
    stem_closed_d = stem_closed_q;
    non_ascii_d   = non_ascii_q;
    ends_ds_d     = ends_ds_q;
    stem_d        = stem_q;
    if (s1_has_char_q) begin
      // Keep only the first fault of the name.
      if (fault_q == VERDICT_OK) begin
        if (is_sep) begin
          fault_d = VERDICT_SEPARATOR;
        end else if (is_illegal) begin
          fault_d = VERDICT_ILLEGAL;
        end
      end
      if (units_q != UNITS_MAX) begin
        units_d = units_q + 2'd1;
      end
      if (!is_dot) begin
        only_dots_d = 1'b0;
      end
      ends_ds_d = is_dot || is_space;
      // The stem runs up to the first dot; keep its first four units.
      if (!stem_closed_q) begin
        if (is_dot) begin
          stem_closed_d = 1'b1;
        end else begin
          if (!is_ascii) begin
            non_ascii_d = 1'b1;
          end
          if (stem_len_q < STEM_KEEP) begin
            stem_d[stem_len_q[1:0]] = low7;
          end
          if (stem_len_q < STEM_MAX) begin
            stem_len_d = stem_len_q + 3'd1;
          end
        end
      end
    end
  end

  // Reserved device names: CON PRN AUX NUL with a three-unit stem, COMn and
  // LPTn with a four-unit stem and a digit from one to nine.
  always_comb begin
    stem_reserved = 1'b0;
    if (!non_ascii_d) begin
      if (stem_len_d == STEM_LEN3) begin
        stem_reserved = word3_is(stem_d[0], stem_d[1], stem_d[2], CH_C, CH_O, CH_N) ||
                        word3_is(stem_d[0], stem_d[1], stem_d[2], CH_P, CH_R, CH_N) ||
                        word3_is(stem_d[0], stem_d[1], stem_d[2], CH_A, CH_U, CH_X) ||
                        word3_is(stem_d[0], stem_d[1], stem_d[2], CH_N, CH_U, CH_L);
      end else if (stem_len_d == STEM_LEN4 && stem_d[3] >= CH_DIGIT_1 &&
                   stem_d[3] <= CH_DIGIT_9) begin
        stem_reserved = word3_is(stem_d[0], stem_d[1], stem_d[2], CH_C, CH_O, CH_M) ||
                        word3_is(stem_d[0], stem_d[1], stem_d[2], CH_L, CH_P, CH_T);
      end
    end
  end

  // Priority: empty, dot names, first fault, trailing dot or space, device.
  always_comb begin
    if (units_d == 2'd0) begin
      verdict_d = VERDICT_EMPTY;
    end else if (only_dots_d && units_d != UNITS_MAX) begin
      verdict_d = VERDICT_RESERVED;
    end else if (fault_d != VERDICT_OK) begin
      verdict_d = fault_d;
    end else if (ends_ds_d) begin
      verdict_d = VERDICT_TRAILING;
    end else if (stem_reserved) begin
      verdict_d = VERDICT_RESERVED;
    end else begin
      verdict_d = VERDICT_OK;
    end
  end

  // Commit the state; clear it after the last item of a name.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_q       <= VERDICT_OK;
      units_q       <= 2'd0;
      only_dots_q   <= 1'b1;
      stem_len_q    <= 3'd0;
      stem_closed_q <= 1'b0;
      non_ascii_q   <= 1'b0;
      ends_ds_q     <= 1'b0;
    end else if (advance) begin
      if (s1_last_q) begin
        fault_q       <= VERDICT_OK;
        units_q       <= 2'd0;
        only_dots_q   <= 1'b1;
        stem_len_q    <= 3'd0;
        stem_closed_q <= 1'b0;
        non_ascii_q   <= 1'b0;
        ends_ds_q     <= 1'b0;
      end else begin
        fault_q       <= fault_d;
        units_q       <= units_d;
        only_dots_q   <= only_dots_d;
        stem_len_q    <= stem_len_d;
        stem_closed_q <= stem_closed_d;
        non_ascii_q   <= non_ascii_d;
        ends_ds_q     <= ends_ds_d;
      end
    end
  end

  // Stem buffer: entries at or above the stem length are never read.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      stem_q <= stem_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register: hold the verdict until it is taken.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      verdict_q <= verdict_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `FNV_ASSERT_NEXT(a_clear_after_last, clk_i, rst_ni, out_load,
    units_q == 2'd0 && only_dots_q && !stem_closed_q && stem_len_q == 3'd0,
    "name state not cleared after last item")
  `FNV_ASSERT_NOW(a_dots_need_units, clk_i, rst_ni, !only_dots_q || stem_closed_q,
    units_q != 2'd0, "dot or non-dot seen without a counted unit")
  `FNV_ASSERT_NOW(a_stem_len_range, clk_i, rst_ni, 1'b1, stem_len_q <= STEM_MAX,
    "stem length beyond saturation")
  `FNV_ASSERT_NEXT(a_verdict_loaded, clk_i, rst_ni, out_load,
    out_valid_o && verdict_o <= VERDICT_TRAILING, "verdict missing or out of range")

endmodule
